[rtl/mpfb_pkg.sv]
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared op codes, color codes and controller command types.
// ----------------------------------------------------------------------------
package mpfb_pkg;

  localparam logic [2:0] OP_PIXEL = 3'd0;
  localparam logic [2:0] OP_HLINE = 3'd1;
  localparam logic [2:0] OP_VLINE = 3'd2;
  localparam logic [2:0] OP_RECT  = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_WHITE = 3'd5;
  localparam logic [2:0] OP_READ  = 3'd6;

  localparam logic [1:0] INK_OFF  = 2'd0;
  localparam logic [1:0] INK_ON   = 2'd1;
  localparam logic [1:0] INK_FLIP = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // capture the command and compute clipped bounds
    logic rd_req;  // read the byte at the walk position
    logic wr_req;  // write back the modified byte
    logic advance; // step the walk position
    logic out_load; // capture the result
  } mpfb_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic empty;   // the clipped area has no pixels
    logic last;    // walk position is the final byte
    logic is_read; // command is a byte read
  } mpfb_sts_t;

endpackage

[rtl/mono_page_framebuffer_drawing_core.sv]
// ----------------------------------------------------------------------------
// mono_page_framebuffer_drawing_core
// Page-layout 1-bit framebuffer with pixel, line, rectangle, fill and byte read commands.
// ----------------------------------------------------------------------------
// A read or a command that draws nothing passes from the check state straight
// to the result state. A drawing command reads and then writes each touched
// byte, so a full clear touches all 1024 bytes; one command at a time.
// After reset a clearing pass writes every byte, one per cycle, while
// in_stall is held high.
module mono_page_framebuffer_drawing_core #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic signed [15:0] in_x_end,
  input  logic signed [15:0] in_y_first,
  input  logic signed [15:0] in_y_last,
  input  logic [15:0]        in_rect_width,
  input  logic [15:0]        in_rect_height,
  input  logic [1:0]         in_color,
  input  logic [9:0]         in_byte_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_read_data,
  output logic [2:0]         out_done_op
);

  mpfb_pkg::mpfb_cmd_t cmd, dp_cmd;
  mpfb_pkg::mpfb_sts_t sts;
  logic                init_load;

  // The reset clear reuses the fill walk: the controller loads a clear-all
  // command into the datapath, which then writes zeros across the store.
  always_comb begin
    dp_cmd      = cmd;
    dp_cmd.load = cmd.load || init_load;
  end

  mpfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .init_load (init_load)
  );

  mpfb_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .cmd            (dp_cmd),
    .sts            (sts),
    .in_op          (init_load ? mpfb_pkg::OP_CLEAR : in_op),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_x_end       (in_x_end),
    .in_y_first     (in_y_first),
    .in_y_last      (in_y_last),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_color       (in_color),
    .in_byte_index  (in_byte_index),
    .out_read_data  (out_read_data),
    .out_done_op    (out_done_op)
  );

endmodule

[rtl/mpfb_datapath.sv]
// ----------------------------------------------------------------------------
// mpfb_datapath
// Frame memory, clipping, walk counters and read-modify-write logic.
// ----------------------------------------------------------------------------
module mpfb_datapath #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                clk,
  input  mpfb_pkg::mpfb_cmd_t cmd,
  output mpfb_pkg::mpfb_sts_t sts,
  input  logic [2:0]          in_op,
  input  logic signed [15:0]  in_x,
  input  logic signed [15:0]  in_y,
  input  logic signed [15:0]  in_x_end,
  input  logic signed [15:0]  in_y_first,
  input  logic signed [15:0]  in_y_last,
  input  logic [15:0]         in_rect_width,
  input  logic [15:0]         in_rect_height,
  input  logic [1:0]          in_color,
  input  logic [9:0]          in_byte_index,
  output logic [7:0]          out_read_data,
  output logic [2:0]          out_done_op
);

  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH = PAGES * SCREEN_WIDTH;
  localparam int XW = $clog2(SCREEN_WIDTH);
  localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int AW = $clog2(DEPTH);
  localparam int YW = PW + 3;

  logic [7:0] mem [DEPTH];

  logic [2:0]    op_r;
  logic [1:0]    color_r;
  logic [XW-1:0] x0_r, x1m_r, xc_r;
  logic [PW-1:0] p1_r, pc_r;
  logic [YW-1:0] y0_r, y1m_r;
  logic          empty_r, fill_r, read_oob_r;
  logic [AW-1:0] rd_addr_r;
  logic [7:0]    rdata_r;
  logic [7:0]    read_data_r;
  logic [2:0]    done_op_r;

  // Clip the command to inclusive bounds in 18-bit arithmetic.
  logic signed [17:0] ax0, ax1, ay0, ay1, cx0, cx1, cy0, cy1, cx1m, cy1m;
  logic               on_screen;

  always_comb begin
    ax0 = 18'(in_x);
    ax1 = 18'(in_x) + 18'sd1;
    ay0 = 18'(in_y);
    ay1 = 18'(in_y) + 18'sd1;
    on_screen = 1'b1;
    unique case (in_op)
      mpfb_pkg::OP_PIXEL: begin
      end
      mpfb_pkg::OP_HLINE: begin
        on_screen = (in_y >= 0) && (18'(in_y) < 18'(SCREEN_HEIGHT));
        if (in_x <= in_x_end) begin
          ax0 = 18'(in_x);
          ax1 = 18'(in_x_end);
        end else begin
          ax0 = 18'(in_x_end);
          ax1 = 18'(in_x);
        end
      end
      mpfb_pkg::OP_VLINE: begin
        on_screen = (in_x >= 0) && (18'(in_x) < 18'(SCREEN_WIDTH));
        if (in_y_first <= in_y_last) begin
          ay0 = 18'(in_y_first);
          ay1 = 18'(in_y_last);
        end else begin
          ay0 = 18'(in_y_last);
          ay1 = 18'(in_y_first);
        end
      end
      mpfb_pkg::OP_RECT: begin
        ax1 = 18'(in_x) + $signed({2'b00, in_rect_width});
        ay1 = 18'(in_y) + $signed({2'b00, in_rect_height});
      end
      default: begin
      end
    endcase
    cx0 = (ax0 < 0) ? 18'sd0 : ax0;
    cy0 = (ay0 < 0) ? 18'sd0 : ay0;
    cx1 = (ax1 > 18'(SCREEN_WIDTH)) ? 18'(SCREEN_WIDTH) : ax1;
    cy1 = (ay1 > 18'(SCREEN_HEIGHT)) ? 18'(SCREEN_HEIGHT) : ay1;
    cx1m = cx1 - 18'sd1;
    cy1m = cy1 - 18'sd1;
  end

  logic fill_op;
  assign fill_op = (in_op == mpfb_pkg::OP_CLEAR) || (in_op == mpfb_pkg::OP_WHITE);

  // Whole-pixel ops and fills both walk a rectangle of pages by columns.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_op;
      color_r    <= in_color;
      fill_r     <= fill_op;
      read_oob_r <= 32'(in_byte_index) >= DEPTH;
      rd_addr_r  <= AW'(in_byte_index);
      if (fill_op) begin
        empty_r <= 1'b0;
        x0_r    <= '0;
        x1m_r   <= XW'(SCREEN_WIDTH - 1);
        y0_r    <= '0;
        y1m_r   <= YW'(PAGES * 8 - 1);
        xc_r    <= '0;
        pc_r    <= '0;
        p1_r    <= PW'(PAGES - 1);
      end else begin
        empty_r <= !on_screen || (cx0 >= cx1) || (cy0 >= cy1) ||
                   (in_op > mpfb_pkg::OP_RECT) || (in_color > mpfb_pkg::INK_FLIP);
        x0_r    <= cx0[XW-1:0];
        x1m_r   <= cx1m[XW-1:0];
        y0_r    <= cy0[YW-1:0];
        y1m_r   <= cy1m[YW-1:0];
        xc_r    <= cx0[XW-1:0];
        pc_r    <= cy0[YW-1:3];
        p1_r    <= cy1m[YW-1:3];
      end
    end else if (cmd.advance) begin
      if (xc_r == x1m_r) begin
        xc_r <= x0_r;
        pc_r <= pc_r + 1'b1;
      end else begin
        xc_r <= xc_r + 1'b1;
      end
    end
  end

  logic [AW-1:0] walk_addr;
  assign walk_addr = AW'(32'(pc_r) * SCREEN_WIDTH + 32'(xc_r));

  // Bit mask of the rows of the current page inside [y0, y1m].
  logic [7:0] mask;
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b] = ({pc_r, 3'(b)} >= y0_r) && ({pc_r, 3'(b)} <= y1m_r);
    end
  end

  logic [7:0] wdata;
  always_comb begin
    if (fill_r) begin
      wdata = (op_r == mpfb_pkg::OP_WHITE) ? 8'hFF : 8'h00;
    end else begin
      case (color_r)
        mpfb_pkg::INK_OFF:  wdata = rdata_r & ~mask;
        mpfb_pkg::INK_ON:   wdata = rdata_r | mask;
        mpfb_pkg::INK_FLIP: wdata = rdata_r ^ mask;
        default:            wdata = rdata_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_req) begin
      rdata_r <= mem[sts.is_read ? rd_addr_r : walk_addr];
    end
    if (cmd.wr_req) begin
      mem[walk_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      done_op_r   <= op_r;
      read_data_r <= (sts.is_read && !read_oob_r) ? rdata_r : 8'h00;
    end
  end

  assign out_done_op   = done_op_r;
  assign out_read_data = read_data_r;

  assign sts.empty   = empty_r;
  assign sts.last    = (xc_r == x1m_r) && (pc_r == p1_r);
  assign sts.is_read = (op_r == mpfb_pkg::OP_READ);

endmodule

[rtl/mpfb_ctrl.sv]
// ----------------------------------------------------------------------------
// mpfb_ctrl
// Command sequencer: reset clear, read-modify-write walk and result handshake.
// ----------------------------------------------------------------------------
module mpfb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output mpfb_pkg::mpfb_cmd_t cmd,
  input  mpfb_pkg::mpfb_sts_t sts,
  output logic                init_load
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_WR    = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;
  localparam logic [2:0] ST_CLR   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  // A new command is taken only once the previous result slot can drain.
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    init_load     = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        init_load = 1'b1;
        state_nxt = ST_CLR;
      end
      ST_CLR: begin
        cmd.wr_req  = 1'b1;
        cmd.advance = 1'b1;
        if (sts.last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.is_read) begin
          cmd.rd_req = 1'b1;
          state_nxt  = ST_OUT;
        end else if (sts.empty) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd_req = 1'b1;
        state_nxt  = ST_WR;
      end
      ST_WR: begin
        cmd.wr_req  = 1'b1;
        cmd.advance = 1'b1;
        state_nxt   = sts.last ? ST_OUT : ST_RD;
      end
      ST_OUT: begin
        if (!(out_valid_r && out_stall)) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !accept) else $error("command taken while busy");
  a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |=> (state_r == ST_WR)) else $error("write did not follow read");
  a_out_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r) else $error("result not presented");
`endif

endmodule

[verif/fb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fb_checker
// Watches both channels of the framebuffer core. It keeps a shadow copy of the
// frame store, works out the result of every accepted command and compares
// each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module fb_checker #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_op,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic signed [15:0] in_x_end,
  input  logic signed [15:0] in_y_first,
  input  logic signed [15:0] in_y_last,
  input  logic [15:0]        in_rect_width,
  input  logic [15:0]        in_rect_height,
  input  logic [1:0]         in_color,
  input  logic [9:0]         in_byte_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_read_data,
  input  logic [2:0]         out_done_op,
  output int                 errors,
  output int                 outstanding
);

  localparam int STORE_BYTES = ((SCREEN_HEIGHT + 7) / 8) * SCREEN_WIDTH;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] done_op;
  } fb_result_t;

  logic [7:0]  shadow_frame [STORE_BYTES];
  fb_result_t  pending_results [$];

  assign outstanding = pending_results.size();

  function automatic void paint_pixel(int px, int py, logic [1:0] color);
    int idx;
    if (px < 0 || px >= SCREEN_WIDTH || py < 0 || py >= SCREEN_HEIGHT) return;
    idx = (py / 8) * SCREEN_WIDTH + px;
    case (color)
      mpfb_pkg::INK_ON:   shadow_frame[idx][py % 8] = 1'b1;
      mpfb_pkg::INK_OFF:  shadow_frame[idx][py % 8] = 1'b0;
      mpfb_pkg::INK_FLIP: shadow_frame[idx][py % 8] = ~shadow_frame[idx][py % 8];
      default: ;
    endcase
  endfunction

  // Paints columns [x0, x1) by rows [y0, y1) after clipping to the screen.
  function automatic void paint_area(int x0, int x1, int y0, int y1,
                                     logic [1:0] color);
    if (x0 < 0) x0 = 0;
    if (x1 > SCREEN_WIDTH) x1 = SCREEN_WIDTH;
    if (y0 < 0) y0 = 0;
    if (y1 > SCREEN_HEIGHT) y1 = SCREEN_HEIGHT;
    for (int i = x0; i < x1; i++)
      for (int j = y0; j < y1; j++)
        paint_pixel(i, j, color);
  endfunction

  function automatic logic [7:0] draw_command();
    int x, y, lo, hi;
    logic [7:0] rd;
    x = int'(in_x);
    y = int'(in_y);
    rd = 8'h00;
    case (in_op)
      mpfb_pkg::OP_PIXEL: paint_pixel(x, y, in_color);
      mpfb_pkg::OP_HLINE: begin
        if (y >= 0 && y < SCREEN_HEIGHT) begin
          lo = int'(in_x_end) < x ? int'(in_x_end) : x;
          hi = int'(in_x_end) < x ? x : int'(in_x_end);
          paint_area(lo, hi, y, y + 1, in_color);
        end
      end
      mpfb_pkg::OP_VLINE: begin
        if (x >= 0 && x < SCREEN_WIDTH) begin
          lo = int'(in_y_last) < int'(in_y_first) ? int'(in_y_last) : int'(in_y_first);
          hi = int'(in_y_last) < int'(in_y_first) ? int'(in_y_first) : int'(in_y_last);
          paint_area(x, x + 1, lo, hi, in_color);
        end
      end
      mpfb_pkg::OP_RECT:
        paint_area(x, x + int'(in_rect_width), y, y + int'(in_rect_height), in_color);
      mpfb_pkg::OP_CLEAR: for (int k = 0; k < STORE_BYTES; k++) shadow_frame[k] = 8'h00;
      mpfb_pkg::OP_WHITE: for (int k = 0; k < STORE_BYTES; k++) shadow_frame[k] = 8'hFF;
      mpfb_pkg::OP_READ:
        if (int'(in_byte_index) < STORE_BYTES) rd = shadow_frame[in_byte_index];
      default: ;
    endcase
    return rd;
  endfunction

  always @(posedge clk) begin
    fb_result_t want;
    if (!rst_n) begin
      errors <= 0;
      pending_results.delete();
      for (int k = 0; k < STORE_BYTES; k++) shadow_frame[k] = 8'h00;
    end else begin
      if (in_valid && !in_stall) begin
        want.read_data = draw_command();
        want.done_op   = in_op;
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          if (errors < 10)
            $display("unexpected result transfer: read_data=%02h done_op=%0d",
                     out_read_data, out_done_op);
          errors <= errors + 1;
        end else begin
          want = pending_results.pop_front();
          if (want.read_data !== out_read_data || want.done_op !== out_done_op) begin
            if (errors < 10)
              $display("result mismatch: expected read_data=%02h done_op=%0d, got %02h %0d",
                       want.read_data, want.done_op, out_read_data, out_done_op);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives drawing commands into the framebuffer core, a directed set first
// and then weighted random traffic, with bursty sending and a stalling
// receiver. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  localparam int W = 128;
  localparam int H = 64;
  localparam int RANDOM_ITEMS = 560;
  localparam int CYCLE_LIMIT = 10000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_op;
  logic signed [15:0] in_x, in_y, in_x_end, in_y_first, in_y_last;
  logic [15:0]        in_rect_width, in_rect_height;
  logic [1:0]         in_color;
  logic [9:0]         in_byte_index;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_read_data;
  logic [2:0]         out_done_op;
  int                 errors;
  int                 outstanding;
  int                 cycle_count = 0;
  int                 burst_left;
  int                 stall_mode = 0;

  mono_page_framebuffer_drawing_core #(.SCREEN_WIDTH(W), .SCREEN_HEIGHT(H)) dut (.*);

  fb_checker #(.SCREEN_WIDTH(W), .SCREEN_HEIGHT(H)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut off if the block ever hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // The receiver switches its stall behavior at random between no stalls at
  // all, light random stalls, or heavy random stalls.
  always @(posedge clk) begin
    if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 25);
      default: out_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // Sends one command and holds it until the block takes the transfer.
  // Between bursts the sender drops valid for a random number of cycles.
  task automatic send_cmd(logic [2:0] op, int x, int y, int x_end, int y_first,
                          int y_last, int w, int h, int color, int bidx);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_op          <= op;
    in_x           <= 16'(x);
    in_y           <= 16'(y);
    in_x_end       <= 16'(x_end);
    in_y_first     <= 16'(y_first);
    in_y_last      <= 16'(y_last);
    in_rect_width  <= 16'(w);
    in_rect_height <= 16'(h);
    in_color       <= 2'(color);
    in_byte_index  <= 10'(bidx);
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Coordinates mostly land near the screen so that clipping edges are hit
  // often; now and then a full 16-bit value exercises every bit.
  function automatic logic [15:0] near_coord(int span);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, span + 16) - 8);
  endfunction

  function automatic logic [1:0] pick_color();
    return ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
  endfunction

  task automatic send_random_cmd();
    int r;
    logic [2:0] op;
    logic [15:0] w, h;
    r = $urandom_range(0, 99);
    if (r < 22)      op = mpfb_pkg::OP_PIXEL;
    else if (r < 36) op = mpfb_pkg::OP_HLINE;
    else if (r < 50) op = mpfb_pkg::OP_VLINE;
    else if (r < 64) op = mpfb_pkg::OP_RECT;
    else if (r < 66) op = mpfb_pkg::OP_CLEAR;
    else if (r < 68) op = mpfb_pkg::OP_WHITE;
    else if (r < 97) op = mpfb_pkg::OP_READ;
    else             op = 3'd7;
    // Large rectangles walk most of the store, so they stay rare.
    if ($urandom_range(0, 29) == 0) begin
      w = 16'($urandom);
      h = 16'($urandom);
    end else begin
      w = 16'($urandom_range(0, 24));
      h = 16'($urandom_range(0, 20));
    end
    send_cmd(op, near_coord(W), near_coord(H), near_coord(W), near_coord(H),
             near_coord(H), w, h, pick_color(), 10'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = '0; in_x = '0; in_y = '0; in_x_end = '0; in_y_first = '0;
    in_y_last = '0; in_rect_width = '0; in_rect_height = '0;
    in_color = '0; in_byte_index = '0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: corners, off-screen pixels, every color including the
    // unknown one, reversed line endpoints, empty and oversized rectangles,
    // whole-buffer fills, the unknown op and reads at both ends of the store.
    send_cmd(mpfb_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, mpfb_pkg::INK_ON, 0);
    send_cmd(mpfb_pkg::OP_PIXEL, W - 1, H - 1, 0, 0, 0, 0, 0, mpfb_pkg::INK_ON, 0);
    send_cmd(mpfb_pkg::OP_PIXEL, -1, 5, 0, 0, 0, 0, 0, mpfb_pkg::INK_ON, 0);
    send_cmd(mpfb_pkg::OP_PIXEL, W, H, 0, 0, 0, 0, 0, mpfb_pkg::INK_ON, 0);
    send_cmd(mpfb_pkg::OP_PIXEL, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0, mpfb_pkg::INK_ON, 0);
    send_cmd(mpfb_pkg::OP_PIXEL, 0, 0, 0, 0, 0, 0, 0, mpfb_pkg::INK_FLIP, 0);
    send_cmd(mpfb_pkg::OP_PIXEL, W - 1, H - 1, 0, 0, 0, 0, 0, mpfb_pkg::INK_OFF, 0);
    send_cmd(mpfb_pkg::OP_PIXEL, 3, 3, 0, 0, 0, 0, 0, 3, 0);
    send_cmd(mpfb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(mpfb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1023);
    send_cmd(mpfb_pkg::OP_HLINE, 200, 9, -50, 0, 0, 0, 0, mpfb_pkg::INK_ON, 0);
    send_cmd(mpfb_pkg::OP_HLINE, 5, 64, 90, 0, 0, 0, 0, mpfb_pkg::INK_ON, 0);
    send_cmd(mpfb_pkg::OP_HLINE, 16'h8000, 12, 16'h7FFF, 0, 0, 0, 0,
             mpfb_pkg::INK_FLIP, 0);
    send_cmd(mpfb_pkg::OP_VLINE, 7, 0, 0, 70, -3, 0, 0, mpfb_pkg::INK_ON, 0);
    send_cmd(mpfb_pkg::OP_VLINE, 128, 0, 0, 0, 20, 0, 0, mpfb_pkg::INK_ON, 0);
    send_cmd(mpfb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 135);
    send_cmd(mpfb_pkg::OP_RECT, 10, 10, 0, 0, 0, 0, 5, mpfb_pkg::INK_ON, 0);
    send_cmd(mpfb_pkg::OP_RECT, 10, 10, 0, 0, 0, 16'hFFFF, 16'hFFFF,
             mpfb_pkg::INK_FLIP, 0);
    send_cmd(mpfb_pkg::OP_RECT, 16'h8000, 16'h8000, 0, 0, 0, 16'hFFFF, 16'hFFFF,
             mpfb_pkg::INK_OFF, 0);
    send_cmd(mpfb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 650);
    send_cmd(mpfb_pkg::OP_WHITE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(mpfb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 513);
    send_cmd(mpfb_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 5);
    send_cmd(mpfb_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 513);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Halfway through, the sender lets the block drain completely.
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      send_random_cmd();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
